// ===== rtl/core/mst_pkg.sv =====
// Package with the constants, types and helper functions of the matrix stack transform block.
`default_nettype none
package mst_pkg;
  localparam int STACK_DEPTH = 32;
  localparam int NUM_MODES   = 2;
  localparam int FRAC_BITS   = 16;

  localparam int MAT_WORDS = 16;
  localparam int SP_W      = $clog2(STACK_DEPTH);
  localparam int MODE_W    = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
  localparam int ADDR_W    = MODE_W + SP_W + 4;
  localparam int ACC_W     = 66;

  localparam logic signed [31:0] FIX_ONE = 32'(64'sd1 << FRAC_BITS);

  typedef enum logic [2:0] {
    F_IDENT = 3'd0,
    F_PUSH  = 3'd1,
    F_POP   = 3'd2,
    F_MULT  = 3'd3,
    F_TRANS = 3'd4,
    F_READ  = 3'd5,
    F_MODE  = 3'd6,
    F_NOP   = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_POP   = 2'd1,
    ST_PUSH  = 2'd2,
    ST_MODE  = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_CALC  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_CLEAR = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic [3:0] idx;
  } mac_ctrl_t;

  function automatic logic signed [31:0] ident_word(input logic [3:0] idx);
    return (idx[1:0] == idx[3:2]) ? FIX_ONE : 32'sd0;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[ACC_W-1:31];
    hi_zeros = ~|v[ACC_W-1:31];
    if (hi_ones || hi_zeros) begin
      return v[31:0];
    end
    return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic [5:0] len6(input logic [SP_W-1:0] sp);
    return 6'(int'(sp) + 1);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/matrix_stack_transform.sv =====
// Top level of the 4x4 transform matrix stack with per-mode stacks and a shared MAC.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------------
//   in       | in_valid_i / in_ready_o | func, row_index, elem_0..3, mode_select
//   out      | out_valid_o/ out_ready_i| status, out_row, out_0..3, stack_length,
//            |                         | current_mode, last
//
// Pop, set mode, unused codes and staged rows go straight to the response.
// Identity writes 16 words; push copies 16 words.
// Multiply and translate read the top, then run 64 MAC steps and drain the MAC.
// Read top loads the top, then gives four row items.
// Reset: bottom entries read as identity through one valid bit per mode; no clearing pass.
// An item is taken only in idle; a stalled output holds the sequencer.
`default_nettype none
module matrix_stack_transform
  import mst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         func_i,
  input  wire logic [1:0]         row_index_i,
  input  wire logic signed [31:0] elem_0_i,
  input  wire logic signed [31:0] elem_1_i,
  input  wire logic signed [31:0] elem_2_i,
  input  wire logic signed [31:0] elem_3_i,
  input  wire logic               mode_select_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic [1:0]              out_row_o,
  output logic signed [31:0]      out_0_o,
  output logic signed [31:0]      out_1_o,
  output logic signed [31:0]      out_2_o,
  output logic signed [31:0]      out_3_o,
  output logic [5:0]              stack_length_o,
  output logic                    current_mode_o,
  output logic                    last_o
);
  state_e              state_q, state_d;
  logic [5:0]          cnt_q, cnt_d;
  func_e               func_q, func_d;
  status_e             stat_q, stat_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [SP_W-1:0]     sp_q [NUM_MODES];
  logic [SP_W-1:0]     sp_d [NUM_MODES];
  logic [NUM_MODES-1:0] bot_vld_q, bot_vld_d;
  logic                rd_pend_q, rd_pend_d;
  logic [3:0]          rd_word_q;
  logic signed [31:0]  tmat_q [MAT_WORDS];
  logic signed [31:0]  stg_q [MAT_WORDS];
  logic signed [31:0]  tr_q [3];

  logic                out_valid_q;
  status_e             o_stat_q;
  logic [1:0]          o_row_q;
  logic signed [31:0]  o_dat_q [4];
  logic [5:0]          o_len_q;
  logic                o_mode_q;
  logic                o_last_q;

  logic [SP_W-1:0]     sp_cur, sp_inc;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic signed [31:0]  ram_wdata, ram_rdata, ld_data;
  mac_ctrl_t           mac_ctrl;
  logic signed [31:0]  mac_a, mac_b;
  logic                res_vld;
  logic [3:0]          res_idx;
  logic signed [31:0]  res_data;
  logic [1:0]          mr, mk, mc;
  logic                acc_in, emit, emit_last;

  assign sp_cur = sp_q[mode_q];
  assign sp_inc = sp_cur + 1'b1;
  assign in_ready_o = (state_q == S_IDLE);
  assign acc_in = in_valid_i && in_ready_o;

  assign ld_data = (sp_cur == '0 && !bot_vld_q[mode_q]) ? ident_word(rd_word_q) : ram_rdata;

  assign mr = cnt_q[5:4];
  assign mc = cnt_q[3:2];
  assign mk = cnt_q[1:0];

  always_comb begin
    mac_a = tmat_q[{mr, mk}];
    if (func_q == F_TRANS) begin
      if (mk == mc) begin
        mac_b = FIX_ONE;
      end else if (mc == 2'd3) begin
        mac_b = tr_q[mk];
      end else begin
        mac_b = 32'sd0;
      end
    end else begin
      mac_b = stg_q[{mk, mc}];
    end
    mac_ctrl.vld   = (state_q == S_CALC);
    mac_ctrl.first = (mk == 2'd0);
    mac_ctrl.last  = (mk == 2'd3);
    mac_ctrl.idx   = {mr, mc};
  end

  mst_mac u_mac (
    .clk_i,
    .rst_ni,
    .ctrl_i     (mac_ctrl),
    .a_i        (mac_a),
    .b_i        (mac_b),
    .res_vld_o  (res_vld),
    .res_idx_o  (res_idx),
    .res_data_o (res_data)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {mode_q, sp_cur, 4'd0};
    ram_wdata = res_data;
    ram_raddr = {mode_q, sp_cur, cnt_q[3:0]};
    if (rd_pend_q && func_q == F_PUSH) begin
      ram_we    = 1'b1;
      ram_waddr = {mode_q, sp_inc, rd_word_q};
      ram_wdata = ld_data;
    end else if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = {mode_q, sp_cur, cnt_q[3:0]};
      ram_wdata = ident_word(cnt_q[3:0]);
    end else if (res_vld) begin
      ram_we    = 1'b1;
      ram_waddr = {mode_q, sp_cur, res_idx};
    end
  end

  mst_ram #(
    .WIDTH (32),
    .DEPTH (2 ** ADDR_W)
  ) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign emit      = (state_q == S_RESP) && !rd_pend_q && (!out_valid_q || out_ready_i);
  assign emit_last = (func_q != F_READ) || (cnt_q[1:0] == 2'd3);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    func_d    = func_q;
    stat_d    = stat_q;
    mode_d    = mode_q;
    sp_d      = sp_q;
    bot_vld_d = bot_vld_q;
    rd_pend_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          func_d  = func_e'(func_i);
          stat_d  = ST_OK;
          cnt_d   = '0;
          state_d = S_RESP;
          case (func_e'(func_i))
            F_IDENT: state_d = S_CLEAR;
            F_PUSH: begin
              if (int'(sp_cur) + 1 >= STACK_DEPTH) begin
                stat_d = ST_PUSH;
              end else begin
                state_d = S_LOAD;
              end
            end
            F_POP: begin
              if (sp_cur == '0) begin
                stat_d = ST_POP;
              end else begin
                sp_d[mode_q] = sp_cur - 1'b1;
              end
            end
            F_MULT: begin
              if (row_index_i == 2'd3) begin
                state_d = S_LOAD;
              end
            end
            F_TRANS, F_READ: state_d = S_LOAD;
            F_MODE: begin
              if (int'(mode_select_i) < NUM_MODES) begin
                mode_d = MODE_W'(mode_select_i);
              end else begin
                stat_d = ST_MODE;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_LOAD: begin
        rd_pend_d = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q[3:0] == 4'd15) begin
          cnt_d   = '0;
          state_d = (func_q == F_PUSH || func_q == F_READ) ? S_RESP : S_CALC;
        end
      end
      S_CALC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'd63) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (res_vld && res_idx == 4'd15) begin
          if (sp_cur == '0) begin
            bot_vld_d[mode_q] = 1'b1;
          end
          state_d = S_RESP;
        end
      end
      S_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[3:0] == 4'd15) begin
          cnt_d = '0;
          if (sp_cur == '0) begin
            bot_vld_d[mode_q] = 1'b1;
          end
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (emit) begin
          cnt_d = cnt_q + 1'b1;
          if (emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (rd_pend_q && func_q == F_PUSH && rd_word_q == 4'd15) begin
      sp_d[mode_q] = sp_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      func_q      <= F_NOP;
      stat_q      <= ST_OK;
      mode_q      <= '0;
      sp_q        <= '{default: '0};
      bot_vld_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      func_q    <= func_d;
      stat_q    <= stat_d;
      mode_q    <= mode_d;
      sp_q      <= sp_d;
      bot_vld_q <= bot_vld_d;
      rd_pend_q <= rd_pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_word_q <= cnt_q[3:0];
    if (rd_pend_q) begin
      tmat_q[rd_word_q] <= ld_data;
    end
    if (acc_in && func_e'(func_i) == F_MULT) begin
      stg_q[{row_index_i, 2'd0}] <= elem_0_i;
      stg_q[{row_index_i, 2'd1}] <= elem_1_i;
      stg_q[{row_index_i, 2'd2}] <= elem_2_i;
      stg_q[{row_index_i, 2'd3}] <= elem_3_i;
    end
    if (acc_in && func_e'(func_i) == F_TRANS) begin
      tr_q[0] <= elem_0_i;
      tr_q[1] <= elem_1_i;
      tr_q[2] <= elem_2_i;
    end
    if (emit) begin
      o_stat_q <= stat_q;
      o_len_q  <= len6(sp_cur);
      o_mode_q <= mode_q[0];
      o_last_q <= emit_last;
      if (func_q == F_READ) begin
        o_row_q <= cnt_q[1:0];
        for (int i = 0; i < 4; i++) begin
          o_dat_q[i] <= tmat_q[{cnt_q[1:0], 2'(i)}];
        end
      end else begin
        o_row_q <= 2'd0;
        for (int i = 0; i < 4; i++) begin
          o_dat_q[i] <= 32'sd0;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = o_stat_q;
  assign out_row_o      = o_row_q;
  assign out_0_o        = o_dat_q[0];
  assign out_1_o        = o_dat_q[1];
  assign out_2_o        = o_dat_q[2];
  assign out_3_o        = o_dat_q[3];
  assign stack_length_o = o_len_q;
  assign current_mode_o = o_mode_q;
  assign last_o         = o_last_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after taking an item");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("matrix store written while idle");

  a_mac_result_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> (state_q == S_CALC || state_q == S_DRAIN))
    else $error("MAC result outside multiply");
endmodule
`default_nettype wire

// ===== rtl/core/mst_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module mst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/mst_mac.sv =====
// Shared multiply-accumulate unit with truncated products and saturated results.
`default_nettype none
module mst_mac
  import mst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mac_ctrl_t          ctrl_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic                    res_vld_o,
  output logic        [3:0]       res_idx_o,
  output logic signed [31:0]      res_data_o
);
  mac_ctrl_t               c1_q, c2_q;
  logic signed [63:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_d, sh;

  assign sh    = ACC_W'(prod_q >>> FRAC_BITS);
  assign acc_d = c1_q.first ? sh : acc_q + sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
    end else begin
      c1_q <= ctrl_i;
      c2_q <= c1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (c1_q.vld) begin
      acc_q <= acc_d;
    end
  end

  assign res_vld_o  = c2_q.vld & c2_q.last;
  assign res_idx_o  = c2_q.idx;
  assign res_data_o = sat32(acc_q);
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for matrix_stack_transform with a scoreboard that predicts the stack.
`default_nettype none
module testbench
  import mst_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 360;

  typedef struct {
    logic [1:0]         status;
    logic [1:0]         row;
    logic signed [31:0] elem [4];
    logic [5:0]         length;
    logic               mode;
    logic               last;
  } row_result_t;

  class stack_scoreboard;
    logic signed [31:0] store [NUM_MODES][STACK_DEPTH][MAT_WORDS];
    logic signed [31:0] staged [MAT_WORDS];
    int                 top_idx [NUM_MODES];
    int                 mode;
    row_result_t        pending [$];
    int                 errors;
    int                 results;
    int                 status_seen [4];

    function void clear();
      for (int m = 0; m < NUM_MODES; m++) begin
        top_idx[m] = 0;
        for (int i = 0; i < MAT_WORDS; i++) begin
          store[m][0][i] = (i % 5 == 0) ? FIX_ONE : 32'sd0;
        end
      end
      mode = 0;
      errors = 0;
      results = 0;
    endfunction

    function void multiply_top(logic signed [31:0] rhs [MAT_WORDS]);
      logic signed [31:0] prod [MAT_WORDS];
      longint acc;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) begin
            acc += (longint'(store[mode][top_idx[mode]][r*4+k]) * longint'(rhs[k*4+c])) >>> FRAC_BITS;
          end
          if (acc > longint'(32'sh7fff_ffff)) prod[r*4+c] = 32'sh7fff_ffff;
          else if (acc < -longint'(64'h8000_0000)) prod[r*4+c] = 32'sh8000_0000;
          else prod[r*4+c] = acc[31:0];
        end
      end
      for (int i = 0; i < MAT_WORDS; i++) store[mode][top_idx[mode]][i] = prod[i];
    endfunction

    function void note_input(logic [2:0] f, logic [1:0] r, logic signed [31:0] e [4], logic ms);
      logic signed [31:0] tr [MAT_WORDS];
      row_result_t res;
      logic [1:0] st;
      int count;
      st = ST_OK;
      count = 1;
      case (f)
        F_IDENT: begin
          for (int i = 0; i < MAT_WORDS; i++) begin
            store[mode][top_idx[mode]][i] = (i % 5 == 0) ? FIX_ONE : 32'sd0;
          end
        end
        F_PUSH: begin
          if (top_idx[mode] + 1 >= STACK_DEPTH) begin
            st = ST_PUSH;
          end else begin
            store[mode][top_idx[mode]+1] = store[mode][top_idx[mode]];
            top_idx[mode]++;
          end
        end
        F_POP: begin
          if (top_idx[mode] == 0) st = ST_POP;
          else top_idx[mode]--;
        end
        F_MULT: begin
          for (int i = 0; i < 4; i++) staged[r*4+i] = e[i];
          if (r == 3) multiply_top(staged);
        end
        F_TRANS: begin
          for (int i = 0; i < MAT_WORDS; i++) tr[i] = (i % 5 == 0) ? FIX_ONE : 32'sd0;
          tr[3] = e[0];
          tr[7] = e[1];
          tr[11] = e[2];
          multiply_top(tr);
        end
        F_READ: count = 4;
        F_MODE: begin
          if (int'(ms) < NUM_MODES) mode = int'(ms);
          else st = ST_MODE;
        end
        default: ;
      endcase
      for (int k = 0; k < count; k++) begin
        res.status = st;
        res.row = (f == F_READ) ? 2'(k) : 2'd0;
        for (int i = 0; i < 4; i++) begin
          res.elem[i] = (f == F_READ) ? store[mode][top_idx[mode]][k*4+i] : 32'sd0;
        end
        res.length = 6'(top_idx[mode] + 1);
        res.mode = mode[0];
        res.last = (k == count - 1);
        pending.push_back(res);
      end
    endfunction

    function void check_result(row_result_t got);
      row_result_t want;
      results++;
      status_seen[got.status]++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, status %0d row %0d", $realtime, got.status, got.row);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
        errors++;
      end
      if (got.row !== want.row) begin
        $display("%0t: out_row exp %0d got %0d", $realtime, want.row, got.row);
        errors++;
      end
      for (int i = 0; i < 4; i++) begin
        if (got.elem[i] !== want.elem[i]) begin
          $display("%0t: out_%0d exp %h got %h", $realtime, i, want.elem[i], got.elem[i]);
          errors++;
        end
      end
      if (got.length !== want.length) begin
        $display("%0t: stack_length exp %0d got %0d", $realtime, want.length, got.length);
        errors++;
      end
      if (got.mode !== want.mode) begin
        $display("%0t: current_mode exp %0d got %0d", $realtime, want.mode, got.mode);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last exp %0d got %0d", $realtime, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         func;
  logic [1:0]         row_index;
  logic signed [31:0] elem_0;
  logic signed [31:0] elem_1;
  logic signed [31:0] elem_2;
  logic signed [31:0] elem_3;
  logic               mode_select;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic [1:0]         out_row;
  logic signed [31:0] out_0;
  logic signed [31:0] out_1;
  logic signed [31:0] out_2;
  logic signed [31:0] out_3;
  logic [5:0]         stack_length;
  logic               current_mode;
  logic               last;

  stack_scoreboard sb;
  logic [3:0]      rows_staged;
  bit              send_quiet;
  int              items_sent;
  int              idle_cycles;

  matrix_stack_transform u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .row_index_i   (row_index),
    .elem_0_i      (elem_0),
    .elem_1_i      (elem_1),
    .elem_2_i      (elem_2),
    .elem_3_i      (elem_3),
    .mode_select_i (mode_select),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .out_row_o     (out_row),
    .out_0_o       (out_0),
    .out_1_o       (out_1),
    .out_2_o       (out_2),
    .out_3_o       (out_3),
    .stack_length_o(stack_length),
    .current_mode_o(current_mode),
    .last_o        (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return FIX_ONE;
        endcase
      end
      1, 2: return $urandom();
      default: return $signed(32'($urandom_range(0, 1 << 19))) - (32'sd1 <<< 18);
    endcase
  endfunction

  task automatic send(logic [2:0] f, logic [1:0] r, logic signed [31:0] e0,
                      logic signed [31:0] e1, logic signed [31:0] e2,
                      logic signed [31:0] e3, logic ms);
    logic signed [31:0] e [4];
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func <= f;
    row_index <= r;
    elem_0 <= e0;
    elem_1 <= e1;
    elem_2 <= e2;
    elem_3 <= e3;
    mode_select <= ms;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    e = '{e0, e1, e2, e3};
    if (f == F_MULT) rows_staged[r] = 1'b1;
    sb.note_input(f, r, e, ms);
    items_sent++;
    if (items_sent % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
    @(negedge clk);
  endtask

  task automatic send_op(logic [2:0] f);
    send(f, 2'd0, pick_value(), pick_value(), pick_value(), pick_value(), 1'b0);
  endtask

  task automatic send_row(logic [1:0] r);
    send(F_MULT, r, pick_value(), pick_value(), pick_value(), pick_value(),
         1'($urandom_range(0, 1)));
  endtask

  task automatic send_noise();
    logic [2:0] f;
    logic [1:0] r;
    f = 3'($urandom_range(0, 7));
    r = 2'($urandom_range(0, 3));
    if (f == F_MULT && r == 2'd3 && !(&rows_staged[2:0])) r = 2'd0;
    send(f, r, $urandom(), $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
  endtask

  // receiver: random stalls, one long hold-off to back up the input
  initial begin
    row_result_t got;
    int gap;
    bit quiet;
    quiet = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (sb.results == 120) gap = 400;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.status = status;
      got.row = out_row;
      got.elem = '{out_0, out_1, out_2, out_3};
      got.length = stack_length;
      got.mode = current_mode;
      got.last = last;
      sb.check_result(got);
      if (sb.results % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
      $display("** matrix_stack_transform: FAILED **");
      $finish;
    end
  end

  initial begin
    int kind;
    int n;
    sb = new();
    sb.clear();
    rows_staged = '0;
    send_quiet = 1'b0;
    items_sent = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    func = F_NOP;
    row_index = '0;
    elem_0 = '0;
    elem_1 = '0;
    elem_2 = '0;
    elem_3 = '0;
    mode_select = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_op(F_READ);
    send_op(F_POP);
    send_op(F_PUSH);
    send(F_TRANS, 2'd0, 32'sh7fff_ffff, 32'sh8000_0000, FIX_ONE, 32'sh1234_5678, 1'b0);
    send_op(F_READ);
    send(F_MULT, 2'd0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, 1'b0);
    send(F_MULT, 2'd1, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, -32'sd1, 1'b1);
    send(F_MULT, 2'd2, -32'sd1, 32'sd0, FIX_ONE, 32'sh8000_0000, 1'b0);
    send(F_MULT, 2'd3, FIX_ONE, -32'sd1, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
    send_op(F_READ);
    send(F_MODE, 2'd0, '0, '0, '0, '0, 1'b1);
    send_op(F_READ);
    send_op(F_POP);
    send_op(F_PUSH);
    send(F_TRANS, 2'd0, -32'sd1, 32'sd1, 32'sh0003_8000, '0, 1'b0);
    send_op(F_IDENT);
    send_op(F_READ);
    send(F_MODE, 2'd0, '0, '0, '0, '0, 1'b0);
    send_op(F_READ);
    send_op(F_NOP);
    send_op(F_IDENT);
    send_op(F_POP);
    send_op(F_READ);

    // fill the stack past its depth, then drain it past the bottom
    repeat (STACK_DEPTH + 1) send_op(F_PUSH);
    send_op(F_READ);
    repeat (STACK_DEPTH + 1) send_op(F_POP);

    while (items_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          n = $urandom_range(0, 2);
          for (int i = 0; i < 3; i++) send_row(2'((i + n) % 3));
          send_row(2'd3);
          send_op(F_READ);
        end
        4: begin
          send_op(F_TRANS);
          send_op(F_READ);
        end
        5: repeat ($urandom_range(1, 4)) send_op(F_PUSH);
        6: repeat ($urandom_range(1, 4)) send_op(F_POP);
        7: begin
          case ($urandom_range(0, 2))
            0: send_op(F_IDENT);
            1: send(F_MODE, 2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
                    $urandom(), 1'($urandom_range(0, 1)));
            default: send_op(F_NOP);
          endcase
        end
        8: repeat ($urandom_range(1, 3)) send_noise();
        default: send_op(F_READ);
      endcase
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, sb.pending.size());
      sb.errors++;
    end
    $display("Sent %0d items, checked %0d results (ok %0d, underflow %0d, overflow %0d).",
             items_sent, sb.results, sb.status_seen[ST_OK], sb.status_seen[ST_POP],
             sb.status_seen[ST_PUSH]);
    if (sb.errors == 0) begin
      $display("** matrix_stack_transform: PASSED **");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("** matrix_stack_transform: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/mst_pkg.sv
rtl/core/mst_ram.sv
rtl/core/mst_mac.sv
rtl/core/matrix_stack_transform.sv
verif/testbench.sv
